// ===== sv/tlb_lookup_lru_defines.svh =====
// Assertion macros used by tlb_lookup_lru.sv; all sample on aclk with reset masked.
`ifndef TLB_LOOKUP_LRU_DEFINES_SVH
`define TLB_LOOKUP_LRU_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TLBL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TLBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tlbl_pkg.sv =====
// Shared constants for the fully associative TLB.
`default_nettype none

package tlbl_pkg;

    localparam int VA_W       = 16;
    localparam int PAGE_W     = 4;
    localparam int OFFSET_W   = 12;
    localparam int MISS_W     = 16;
    localparam int ENTRY_OUT_W = 3;
    localparam int FRAME_BASE = 2;

    localparam logic [PAGE_W-1:0] TAG_RESET = '1;
    localparam logic [MISS_W-1:0] MISS_MAX  = '1;

endpackage

`default_nettype wire

// ===== sv/tlbl_cell.sv =====
// One TLB entry: tag, valid and recency rank, plus one stage of the lookup chain.
`default_nettype none

module tlbl_cell #(
    parameter int ENTRIES = 8,
    parameter int INDEX   = 0
) (
    aclk,
    aresetn,
    page,
    srch_in,
    srch_out,
    upd
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
    localparam logic [IDX_W-1:0] MAX_RANK = IDX_W'(ENTRIES - 1);

    typedef struct packed {
        logic                      hit;
        logic [IDX_W-1:0]          hit_idx;
        logic [IDX_W-1:0]          hit_rank;
        logic                      inv;
        logic [IDX_W-1:0]          inv_idx;
        logic [IDX_W-1:0]          inv_rank;
        logic                      min_ok;
        logic [IDX_W-1:0]          min_idx;
        logic [IDX_W-1:0]          min_rank;
        logic [tlbl_pkg::PAGE_W-1:0] min_tag;
    } srch_t;

    typedef struct packed {
        logic             en;
        logic             fill;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] rank;
    } upd_t;

    input  logic                        aclk;
    input  logic                        aresetn;
    input  logic [tlbl_pkg::PAGE_W-1:0] page;
    input  srch_t                       srch_in;
    output srch_t                       srch_out;
    input  upd_t                        upd;

    logic [tlbl_pkg::PAGE_W-1:0] tag_reg, tag_next;
    logic                        valid_reg, valid_next;
    logic [IDX_W-1:0]            rank_reg, rank_next;
    srch_t                       srch_reg, srch_next;
    logic                        hit_here;

    assign hit_here = valid_reg && (tag_reg == page);

    // Fold this entry into the running search record; earlier cells win ties.
    always_comb begin
        srch_next = srch_in;
        if (!srch_in.hit && hit_here) begin
            srch_next.hit      = 1'b1;
            srch_next.hit_idx  = MY_IDX;
            srch_next.hit_rank = rank_reg;
        end
        if (!srch_in.inv && !valid_reg) begin
            srch_next.inv      = 1'b1;
            srch_next.inv_idx  = MY_IDX;
            srch_next.inv_rank = rank_reg;
        end
        if (!srch_in.min_ok || (rank_reg < srch_in.min_rank)) begin
            srch_next.min_ok   = 1'b1;
            srch_next.min_idx  = MY_IDX;
            srch_next.min_rank = rank_reg;
            srch_next.min_tag  = tag_reg;
        end
    end

    always_comb begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.en) begin
            if (upd.idx == MY_IDX) begin
                rank_next = MAX_RANK;
                if (upd.fill) begin
                    tag_next   = page;
                    valid_next = 1'b1;
                end
            end else if (rank_reg > upd.rank) begin
                rank_next = rank_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg   <= tlbl_pkg::TAG_RESET;
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            tag_reg   <= tag_next;
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        srch_reg <= srch_next;
    end

    assign srch_out = srch_reg;

endmodule

`default_nettype wire

// ===== sv/tlb_lookup_lru.sv =====
// Per request: the lookup record walks the entry chain one cell per cycle in ST_SCAN,
// then ST_UPD updates tags and recency ranks and loads the output register, waiting
// while the previous result is unaccepted. A request is taken only in ST_IDLE.
// A new request is taken while the previous result still waits in the output register.
// Reset (aresetn low, synchronous): all entries invalid with tag 0xF and rank 0,
// miss counter cleared, no result pending.
`default_nettype none

module tlb_lookup_lru #(
    parameter int ENTRIES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlbl_pkg::VA_W-1:0]     s_virtual_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_evicted,
    output logic [tlbl_pkg::PAGE_W-1:0]   m_evicted_page,
    output logic [tlbl_pkg::ENTRY_OUT_W-1:0] m_entry_used,
    output logic [tlbl_pkg::ENTRY_OUT_W-1:0] m_frame,
    output logic [tlbl_pkg::VA_W-1:0]     m_physical_address,
    output logic [tlbl_pkg::MISS_W-1:0]   m_miss_count
);

`include "tlb_lookup_lru_defines.svh"

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W:0]   ENT_EXT  = (IDX_W + 1)'(ENTRIES);
    localparam logic [IDX_W:0]   BASE_EXT = (IDX_W + 1)'(tlbl_pkg::FRAME_BASE);

    typedef struct packed {
        logic                      hit;
        logic [IDX_W-1:0]          hit_idx;
        logic [IDX_W-1:0]          hit_rank;
        logic                      inv;
        logic [IDX_W-1:0]          inv_idx;
        logic [IDX_W-1:0]          inv_rank;
        logic                      min_ok;
        logic [IDX_W-1:0]          min_idx;
        logic [IDX_W-1:0]          min_rank;
        logic [tlbl_pkg::PAGE_W-1:0] min_tag;
    } srch_t;

    typedef struct packed {
        logic             en;
        logic             fill;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] rank;
    } upd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                cnt_reg, cnt_next;
    logic [tlbl_pkg::VA_W-1:0]       va_reg;
    logic [tlbl_pkg::MISS_W-1:0]     miss_cnt_reg, miss_cnt_next;

    logic                            m_valid_reg;
    logic                            m_hit_reg;
    logic                            m_evicted_reg;
    logic [tlbl_pkg::PAGE_W-1:0]     m_evicted_page_reg;
    logic [tlbl_pkg::ENTRY_OUT_W-1:0] m_entry_used_reg;
    logic [tlbl_pkg::ENTRY_OUT_W-1:0] m_frame_reg;
    logic [tlbl_pkg::VA_W-1:0]       m_physical_address_reg;
    logic [tlbl_pkg::MISS_W-1:0]     m_miss_count_reg;

    srch_t                           chain [ENTRIES+1];
    srch_t                           fin;
    upd_t                            upd;
    logic [tlbl_pkg::PAGE_W-1:0]     page;
    logic                            s_fire;
    logic                            upd_fire;
    logic                            miss;
    logic                            evict;
    logic [IDX_W-1:0]                used_idx;
    logic [IDX_W-1:0]                used_rank;
    logic [IDX_W:0]                  frame_sum;
    logic [IDX_W-1:0]                frame;

    assign page     = va_reg[tlbl_pkg::VA_W-1:tlbl_pkg::OFFSET_W];
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign upd_fire = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);

    // The head of the chain starts with an empty search record.
    assign chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        tlbl_cell #(
            .ENTRIES (ENTRIES),
            .INDEX   (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .page     (page),
            .srch_in  (chain[i]),
            .srch_out (chain[i+1]),
            .upd      (upd)
        );
    end

    assign fin   = chain[ENTRIES];
    assign miss  = !fin.hit;
    assign evict = miss && !fin.inv;

    always_comb begin
        if (fin.hit) begin
            used_idx  = fin.hit_idx;
            used_rank = fin.hit_rank;
        end else if (fin.inv) begin
            used_idx  = fin.inv_idx;
            used_rank = fin.inv_rank;
        end else begin
            used_idx  = fin.min_idx;
            used_rank = fin.min_rank;
        end
    end

    // used_idx + base stays below twice ENTRIES, so one conditional subtract wraps it.
    always_comb begin
        frame_sum = {1'b0, used_idx} + BASE_EXT;
        if (frame_sum >= ENT_EXT) begin
            frame_sum = frame_sum - ENT_EXT;
        end
        frame = frame_sum[IDX_W-1:0];
    end

    assign upd.en   = upd_fire;
    assign upd.fill = miss;
    assign upd.idx  = used_idx;
    assign upd.rank = used_rank;

    always_comb begin
        miss_cnt_next = miss_cnt_reg;
        if (upd_fire && miss && (miss_cnt_reg != tlbl_pkg::MISS_MAX)) begin
            miss_cnt_next = miss_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_UPD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPD: begin
                if (upd_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            if (upd_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            va_reg <= s_virtual_address;
        end
        if (upd_fire) begin
            m_hit_reg          <= fin.hit;
            m_evicted_reg      <= evict;
            m_evicted_page_reg <= evict ? fin.min_tag : '0;
            m_entry_used_reg   <= tlbl_pkg::ENTRY_OUT_W'(used_idx);
            m_frame_reg        <= tlbl_pkg::ENTRY_OUT_W'(frame);
            m_physical_address_reg <= {tlbl_pkg::PAGE_W'(frame),
                                       va_reg[tlbl_pkg::OFFSET_W-1:0]};
            m_miss_count_reg   <= miss_cnt_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_hit              = m_hit_reg;
    assign m_evicted          = m_evicted_reg;
    assign m_evicted_page     = m_evicted_page_reg;
    assign m_entry_used       = m_entry_used_reg;
    assign m_frame            = m_frame_reg;
    assign m_physical_address = m_physical_address_reg;
    assign m_miss_count       = m_miss_count_reg;

    `TLBL_ASSERT_NEXT(a_accept_starts_scan, s_fire, (state_reg == ST_SCAN) && (cnt_reg == '0), "accepted request did not start the chain walk")
    `TLBL_ASSERT_NEXT(a_hit_keeps_misses, upd_fire && fin.hit, $stable(miss_cnt_reg), "miss counter moved on a hit")
    `TLBL_ASSERT_SAME(a_evict_only_on_miss, m_valid && m_hit, !m_evicted && (m_evicted_page == '0), "hit result reports an eviction")

endmodule

`default_nettype wire

// ===== tb/tlb_lookup_lru_test.sv =====
// Self-checking testbench for the fully associative LRU TLB, with its own translation predictor.
module tlb_lookup_lru_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 8;
    localparam int RANDOM_PER_PHASE = 310;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic                             hit;
        logic                             evicted;
        logic [tlbl_pkg::PAGE_W-1:0]      evicted_page;
        logic [tlbl_pkg::ENTRY_OUT_W-1:0] entry_used;
        logic [tlbl_pkg::ENTRY_OUT_W-1:0] frame;
        logic [tlbl_pkg::VA_W-1:0]        physical_address;
        logic [tlbl_pkg::MISS_W-1:0]      miss_count;
    } translation_t;

    typedef struct {
        logic [tlbl_pkg::VA_W-1:0] va;
        int unsigned               idle_pct;
        int unsigned               stall_pct;
    } request_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [tlbl_pkg::VA_W-1:0] s_virtual_address;
    logic m_valid;
    logic m_ready;
    logic m_hit;
    logic m_evicted;
    logic [tlbl_pkg::PAGE_W-1:0] m_evicted_page;
    logic [tlbl_pkg::ENTRY_OUT_W-1:0] m_entry_used;
    logic [tlbl_pkg::ENTRY_OUT_W-1:0] m_frame;
    logic [tlbl_pkg::VA_W-1:0] m_physical_address;
    logic [tlbl_pkg::MISS_W-1:0] m_miss_count;

    request_t pending_requests[$];
    translation_t expected_translations[$];

    // Mirror of the TLB contents.
    logic [tlbl_pkg::PAGE_W-1:0] tag_mirror[ENTRIES];
    bit                          valid_mirror[ENTRIES];
    int                          rank_mirror[ENTRIES];
    logic [tlbl_pkg::MISS_W-1:0] misses_seen;

    int unsigned recv_stall_pct;
    logic        req_taken;
    int          failures;
    int          mismatches;
    int          cycle_count;

    tlb_lookup_lru #(
        .ENTRIES(ENTRIES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_virtual_address(s_virtual_address),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_hit(m_hit),
        .m_evicted(m_evicted),
        .m_evicted_page(m_evicted_page),
        .m_entry_used(m_entry_used),
        .m_frame(m_frame),
        .m_physical_address(m_physical_address),
        .m_miss_count(m_miss_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic translation_t predict_translation(logic [tlbl_pkg::VA_W-1:0] va);
        translation_t r;
        logic [tlbl_pkg::PAGE_W-1:0] page;
        int used;
        int best;
        int old_rank;
        int f;
        bit found;
        r = '0;
        page = va[tlbl_pkg::VA_W-1 -: tlbl_pkg::PAGE_W];
        used = 0;
        found = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (!found && valid_mirror[k] && tag_mirror[k] == page) begin
                used = k;
                found = 1'b1;
            end
        end
        r.hit = found;
        if (!found) begin
            if (misses_seen != tlbl_pkg::MISS_MAX) begin
                misses_seen = misses_seen + 1'b1;
            end
            for (int k = 0; k < ENTRIES; k++) begin
                if (!found && !valid_mirror[k]) begin
                    used = k;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // Full: the lowest rank is the least recent, and ties go to the lowest index.
                best = rank_mirror[0];
                used = 0;
                for (int k = 1; k < ENTRIES; k++) begin
                    if (rank_mirror[k] < best) begin
                        best = rank_mirror[k];
                        used = k;
                    end
                end
                r.evicted = 1'b1;
                r.evicted_page = tag_mirror[used];
            end
            tag_mirror[used] = page;
            valid_mirror[used] = 1'b1;
        end
        old_rank = rank_mirror[used];
        for (int k = 0; k < ENTRIES; k++) begin
            if (rank_mirror[k] > old_rank) begin
                rank_mirror[k] = rank_mirror[k] - 1;
            end
        end
        rank_mirror[used] = ENTRIES - 1;
        f = (tlbl_pkg::FRAME_BASE + used) % ENTRIES;
        r.entry_used = used[tlbl_pkg::ENTRY_OUT_W-1:0];
        r.frame = f[tlbl_pkg::ENTRY_OUT_W-1:0];
        r.physical_address = {f[tlbl_pkg::PAGE_W-1:0], va[tlbl_pkg::OFFSET_W-1:0]};
        r.miss_count = misses_seen;
        return r;
    endfunction

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual) begin
            failures++;
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s at %0t: expected 0x%0h, got 0x%0h",
                         name, $realtime, expected, actual);
            end
        end
    endfunction

    // Monitor: checks results and predicts each request as it is accepted.
    always @(posedge aclk) begin : monitor
        translation_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_translations.size() == 0) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result at %0t: physical address 0x%0h",
                                 $realtime, m_physical_address);
                    end
                end else begin
                    want = expected_translations.pop_front();
                    check_field("hit", want.hit, m_hit);
                    check_field("evicted", want.evicted, m_evicted);
                    check_field("evicted_page", want.evicted_page, m_evicted_page);
                    check_field("entry_used", want.entry_used, m_entry_used);
                    check_field("frame", want.frame, m_frame);
                    check_field("physical_address", want.physical_address,
                                m_physical_address);
                    check_field("miss_count", want.miss_count, m_miss_count);
                end
            end
            if (s_valid && s_ready) begin
                expected_translations.push_back(predict_translation(s_virtual_address));
            end
        end
        req_taken <= aresetn && s_valid && s_ready;
    end

    // Driver: presents requests and the result-side ready on the falling edge.
    always @(negedge aclk) begin : driver
        request_t req;
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            next_valid = s_valid && !req_taken;
            if (!next_valid && pending_requests.size() != 0) begin
                if ($urandom_range(99) >= pending_requests[0].idle_pct) begin
                    req = pending_requests.pop_front();
                    s_virtual_address <= req.va;
                    recv_stall_pct = req.stall_pct;
                    next_valid = 1'b1;
                end
            end
            s_valid <= next_valid;
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_request(input logic [tlbl_pkg::VA_W-1:0] va,
                               input int unsigned idle_pct,
                               input int unsigned stall_pct);
        request_t req;
        req.va = va;
        req.idle_pct = idle_pct;
        req.stall_pct = stall_pct;
        pending_requests.push_back(req);
    endtask

    function automatic logic [tlbl_pkg::OFFSET_W-1:0] pick_offset();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return '0;
        end else if (roll < 20) begin
            return '1;
        end
        return tlbl_pkg::OFFSET_W'($urandom_range(4095));
    endfunction

    initial begin : stimulus
        int unsigned idle_table[4];
        int unsigned stall_table[4];
        int unsigned roll;
        int unsigned base_page;
        int unsigned set_size;
        int unsigned burst_start;
        int unsigned burst_len;
        int count;
        logic [tlbl_pkg::PAGE_W-1:0] page;

        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_virtual_address = '0;
        req_taken = 1'b0;
        recv_stall_pct = 0;
        failures = 0;
        mismatches = 0;
        cycle_count = 0;
        misses_seen = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            tag_mirror[k] = tlbl_pkg::TAG_RESET;
            valid_mirror[k] = 1'b0;
            rank_mirror[k] = 0;
        end

        // Directed: address extremes, a page equal to the reset tag while it is still
        // invalid, filling every entry, hits, and LRU evictions.
        add_request(16'h0000, 0, 0);
        add_request(16'h0FFF, 0, 0);
        add_request(16'hFFFF, 0, 0);
        add_request(16'hF000, 0, 0);
        for (int p = 1; p <= 6; p++) begin
            add_request({4'(p), pick_offset()}, 0, 0);
        end
        add_request(16'h7ABC, 0, 0);
        add_request(16'h3555, 0, 0);
        add_request(16'h0AAA, 0, 0);
        add_request(16'h5123, 0, 0);
        add_request(16'h8000, 0, 0);
        add_request(16'h9FFF, 0, 0);
        add_request(16'hA800, 0, 0);
        add_request(16'h7000, 0, 0);

        idle_table = '{0, 58, 0, 30};
        stall_table = '{0, 0, 58, 30};
        for (int ph = 0; ph < 4; ph++) begin
            count = 0;
            base_page = 0;
            set_size = 4;
            while (count < RANDOM_PER_PHASE) begin
                if (count % 40 == 0) begin
                    base_page = $urandom_range(15);
                    set_size = $urandom_range(4, 10);
                end
                roll = $urandom_range(99);
                if (roll < 50) begin
                    // Small working set: mostly hits, with evictions when it exceeds the TLB.
                    page = tlbl_pkg::PAGE_W'((base_page + $urandom_range(set_size - 1)) % 16);
                    add_request({page, pick_offset()}, idle_table[ph], stall_table[ph]);
                    count++;
                end else if (roll < 80) begin
                    add_request(tlbl_pkg::VA_W'($urandom_range(65535)), idle_table[ph],
                                stall_table[ph]);
                    count++;
                end else begin
                    // Cyclic sweep over more pages than entries: a run of LRU evictions.
                    burst_start = $urandom_range(15);
                    burst_len = $urandom_range(9, 20);
                    for (int i = 0; i < burst_len; i++) begin
                        page = tlbl_pkg::PAGE_W'((burst_start + i % 9) % 16);
                        add_request({page, pick_offset()}, idle_table[ph], stall_table[ph]);
                    end
                    count += burst_len;
                end
            end
        end

        for (int i = 0; i < 40; i++) begin
            add_request(tlbl_pkg::VA_W'($urandom_range(65535)), 30, 30);
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid || expected_translations.size() != 0) begin
            @(posedge aclk);
        end
        repeat (ENTRIES + 4) @(posedge aclk);
        failures += expected_translations.size();
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
